// File: sv/ffh_pkg.sv
// ----------------------------------------------------------------------------
// ffh_pkg - shared constants for the fault formation height map
// Field widths, register indexes, register reset values, op codes and divider sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package ffh_pkg;

	localparam int GRID_SIZE_DEF = 128;

	localparam int COORD_W    = 7;
	localparam int CELL_W     = 24;
	localparam int DELTA_W    = 8;
	localparam int PASS_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DELTA    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PASSES = 2'd2;

	localparam logic [DELTA_W-1:0] MAX_DELTA_RST    = 8'd255;
	localparam logic [DELTA_W-1:0] MIN_DELTA_RST    = 8'd0;
	localparam logic [PASS_W-1:0]  TOTAL_PASSES_RST = 16'd1000;

	localparam logic OP_FAULT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// product of span and pass count is below 2**24 in magnitude
	localparam int DIV_STEPS = 24;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

`default_nettype wire

// File: sv/fault_formation_heightmap.sv
// ----------------------------------------------------------------------------
// fault_formation_heightmap - fault formation terrain generator
// Square height map in block memory, raised one fault line at a time.
// ----------------------------------------------------------------------------
// After reset the map is cleared one cell per cycle, and no item is taken
// until that pass ends; configuration writes are taken throughout. A read
// item goes through the read, read-data and hand-off states. A fault item
// goes through the span times count product, the bit-serial divider that
// sets the pass height, a state to load the height, then one cell per cycle
// through the read-modify-write port of the map memory, a drain state and
// the hand-off state. Once the count has reached the total the divider is
// skipped. A fault whose two points coincide goes from the product state
// straight to hand-off. The block takes one item at a time and is ready
// again the cycle after a result is handed off; a finished result waits in
// the output register while the next item is accepted.
`default_nettype none

module fault_formation_heightmap #(
	parameter int GRID_SIZE = ffh_pkg::GRID_SIZE_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic [ffh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ffh_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           op,
	input  wire logic [ffh_pkg::COORD_W-1:0]    line_x1,
	input  wire logic [ffh_pkg::COORD_W-1:0]    line_z1,
	input  wire logic [ffh_pkg::COORD_W-1:0]    line_x2,
	input  wire logic [ffh_pkg::COORD_W-1:0]    line_z2,
	input  wire logic [ffh_pkg::COORD_W-1:0]    cell_x,
	input  wire logic [ffh_pkg::COORD_W-1:0]    cell_z,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [ffh_pkg::CELL_W-1:0]          value,
	output logic [ffh_pkg::PASS_W-1:0]          passes_done
);

	import ffh_pkg::*;

	localparam int CELLS   = GRID_SIZE * GRID_SIZE;
	localparam int AW      = $clog2(CELLS);
	localparam int CW      = $clog2(GRID_SIZE);
	localparam int XW      = (CW > COORD_W) ? CW : COORD_W;
	localparam int CROSS_W = XW + 10;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_READ  = 10'b00_0000_0100,
		S_RDATA = 10'b00_0000_1000,
		S_MUL   = 10'b00_0001_0000,
		S_DIV   = 10'b00_0010_0000,
		S_HGT   = 10'b00_0100_0000,
		S_SWEEP = 10'b00_1000_0000,
		S_DRAIN = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [DELTA_W-1:0] max_q, min_q;
	logic [PASS_W-1:0]  total_q;
	logic [PASS_W-1:0]  total_eff;

	// latched item
	logic [COORD_W-1:0] x1_q, z1_q, x2_q, z2_q, cx_q, cz_q;

	logic [PASS_W-1:0]  pc_q;
	logic [CELL_W-1:0]  res_q;
	logic [DELTA_W-1:0] h_q;
	logic               sat_q;

	// divider
	logic [DIV_STEPS-1:0] dvd_q;
	logic [PASS_W-1:0]    rem_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [PASS_W:0]      trial;
	logic                 trial_ge;

	// sweep
	logic [AW-1:0]             sw_addr_q;
	logic [CW-1:0]             x_q;
	logic signed [CROSS_W-1:0] row_q, cross_q;
	logic signed [CROSS_W-1:0] dx_e, dz_e, cross0;
	logic                      valid_s1, raise_s1;
	logic [AW-1:0]             addr_s1;

	// map memory
	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] mem_rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa, mem_ra, cell_addr;
	logic [CELL_W-1:0] mem_wd;
	logic [CELL_W:0]   sum;
	logic              cell_in_map;

	// pass height product
	logic signed [DELTA_W:0]  span;
	logic signed [PASS_W:0]   pc_s;
	logic signed [PASS_W+DELTA_W+1:0] prod;
	logic [PASS_W+DELTA_W+1:0]        prod_mag;

	assign total_eff = (total_q == '0) ? PASS_W'(1) : total_q;
	assign in_stall  = (state_q != S_IDLE);

	assign span     = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
	assign pc_s     = $signed({1'b0, pc_q});
	assign prod     = (PASS_W+DELTA_W+2)'(span) * (PASS_W+DELTA_W+2)'(pc_s);
	assign prod_mag = prod[PASS_W+DELTA_W+1] ? $unsigned(-prod) : $unsigned(prod);

	assign trial    = {rem_q, dvd_q[DIV_STEPS-1]};
	assign trial_ge = (trial >= {1'b0, total_eff});

	assign dx_e   = CROSS_W'($signed({1'b0, x2_q}) - $signed({1'b0, x1_q}));
	assign dz_e   = CROSS_W'($signed({1'b0, z2_q}) - $signed({1'b0, z1_q}));
	// cross product at column 0, row 0
	assign cross0 = dx_e * CROSS_W'($signed({1'b0, z1_q}))
	              - dz_e * CROSS_W'($signed({1'b0, x1_q}));

	assign cell_in_map = (32'(cx_q) < GRID_SIZE) && (32'(cz_q) < GRID_SIZE);
	assign cell_addr   = AW'(32'(cz_q) * GRID_SIZE + 32'(cx_q));

	assign sum    = {1'b0, mem_rd_q} + (CELL_W+1)'(h_q);
	assign mem_ra = (state_q == S_READ) ? cell_addr : sw_addr_q;
	assign mem_we = (state_q == S_CLEAR) || (valid_s1 && raise_s1);
	assign mem_wa = (state_q == S_CLEAR) ? sw_addr_q : addr_s1;
	assign mem_wd = (state_q == S_CLEAR) ? '0 :
	                (sum[CELL_W] ? {CELL_W{1'b1}} : sum[CELL_W-1:0]);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_DELTA_RST;
			min_q   <= MIN_DELTA_RST;
			total_q <= TOTAL_PASSES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_DELTA:    max_q   <= cfg_data[DELTA_W-1:0];
				REG_MIN_DELTA:    min_q   <= cfg_data[DELTA_W-1:0];
				REG_TOTAL_PASSES: total_q <= cfg_data[PASS_W-1:0];
				default: ;
			endcase
		end
	end

	// item latch and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			x1_q <= line_x1;
			z1_q <= line_z1;
			x2_q <= line_x2;
			z2_q <= line_z2;
			cx_q <= cell_x;
			cz_q <= cell_z;
		end
		case (state_q)
			S_RDATA: res_q <= cell_in_map ? mem_rd_q : '0;
			S_MUL: begin
				res_q     <= '0;
				sat_q     <= (pc_q >= total_eff);
				neg_q     <= prod[PASS_W+DELTA_W+1];
				dvd_q     <= prod_mag[DIV_STEPS-1:0];
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			S_DIV: begin
				rem_q     <= trial_ge ? PASS_W'(trial - {1'b0, total_eff}) : trial[PASS_W-1:0];
				dvd_q     <= {dvd_q[DIV_STEPS-2:0], trial_ge};
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			S_HGT: begin
				// quotient is below 256 in magnitude, so the height fits
				if (sat_q)
					h_q <= min_q;
				else if (neg_q)
					h_q <= max_q + dvd_q[DELTA_W-1:0];
				else
					h_q <= max_q - dvd_q[DELTA_W-1:0];
				x_q     <= '0;
				row_q   <= cross0;
				cross_q <= cross0;
			end
			S_SWEEP: begin
				if (x_q == CW'(GRID_SIZE - 1)) begin
					x_q     <= '0;
					row_q   <= row_q - dx_e;
					cross_q <= row_q - dx_e;
				end else begin
					x_q     <= x_q + CW'(1);
					cross_q <= cross_q + dz_e;
				end
			end
			S_DRAIN: res_q <= CELL_W'(h_q);
			default: ;
		endcase
		raise_s1 <= (cross_q > 0);
		addr_s1  <= sw_addr_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sw_addr_q   <= '0;
			valid_s1    <= 1'b0;
			pc_q        <= '0;
			out_valid   <= 1'b0;
			value       <= '0;
			passes_done <= '0;
		end else begin
			valid_s1 <= (state_q == S_SWEEP);
			if (state_q == S_DONE && (!out_valid || !out_stall))
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (sw_addr_q == AW'(CELLS - 1)) begin
						sw_addr_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						sw_addr_q <= sw_addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_valid)
						state_q <= (op == OP_READ) ? S_READ : S_MUL;
				end
				S_READ:  state_q <= S_RDATA;
				S_RDATA: state_q <= S_DONE;
				S_MUL: begin
					// coincident points leave the map and the count alone
					if (x1_q == x2_q && z1_q == z2_q)
						state_q <= S_DONE;
					else if (pc_q >= total_eff)
						state_q <= S_HGT;
					else
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= S_HGT;
				end
				S_HGT: state_q <= S_SWEEP;
				S_SWEEP: begin
					if (sw_addr_q == AW'(CELLS - 1)) begin
						sw_addr_q <= '0;
						state_q   <= S_DRAIN;
					end else begin
						sw_addr_q <= sw_addr_q + AW'(1);
					end
				end
				S_DRAIN: begin
					pc_q    <= (pc_q < total_eff) ? pc_q + PASS_W'(1) : total_eff;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid || !out_stall) begin
						value       <= res_q;
						passes_done <= pc_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// a result appears only from the hand-off state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result shown outside hand-off");

	// a pass advances the count by one or pins it at the limit
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |=> (pc_q == $past(pc_q) + PASS_W'(1)) ||
		                         (pc_q == $past(total_eff)))
		else $error("pass count stepped wrongly");

	// pass height lies between the two delta registers
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |->
		((max_q >= min_q) ? (h_q <= max_q && h_q >= min_q)
		                  : (h_q >= max_q && h_q <= min_q)))
		else $error("pass height out of range");

	// every sweep starts at the first cell
	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_SWEEP) |-> (sw_addr_q == '0) && (x_q == '0))
		else $error("sweep did not start at cell zero");

endmodule

`default_nettype wire

// File: bench/ffh_checker.sv
// ----------------------------------------------------------------------------
// ffh_checker - result checker for the fault formation height map
// Watches the configuration port and both item channels, keeps its own copy
// of the height map, pass count and registers, and compares every result
// item field by field with the oldest one it has predicted.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module ffh_checker #(
	parameter int GRID = ffh_pkg::GRID_SIZE_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ffh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ffh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic                           op,
	input  wire logic [ffh_pkg::COORD_W-1:0]    line_x1,
	input  wire logic [ffh_pkg::COORD_W-1:0]    line_z1,
	input  wire logic [ffh_pkg::COORD_W-1:0]    line_x2,
	input  wire logic [ffh_pkg::COORD_W-1:0]    line_z2,
	input  wire logic [ffh_pkg::COORD_W-1:0]    cell_x,
	input  wire logic [ffh_pkg::COORD_W-1:0]    cell_z,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic [ffh_pkg::CELL_W-1:0]     value,
	input  wire logic [ffh_pkg::PASS_W-1:0]     passes_done,
	output int                                  pending,
	output int                                  errors
);

	import ffh_pkg::*;

	typedef struct packed {
		logic [CELL_W-1:0] value;
		logic [PASS_W-1:0] passes;
	} ffh_result_t;

	localparam logic [CELL_W-1:0] CELL_TOP = '1;

	logic [CELL_W-1:0]  height_model [GRID*GRID];
	logic [PASS_W-1:0]  pass_count;
	logic [DELTA_W-1:0] hi_delta;
	logic [DELTA_W-1:0] lo_delta;
	logic [PASS_W-1:0]  pass_span;
	ffh_result_t        results_due [$];

	// height of the next pass; the quotient truncates toward zero
	function automatic logic [CELL_W-1:0] fault_height();
		int total;
		int span;
		int q;
		total = (pass_span == '0) ? 1 : int'(pass_span);
		if (int'(pass_count) >= total)
			return CELL_W'(lo_delta);
		span = int'(hi_delta) - int'(lo_delta);
		q = (span * int'(pass_count)) / total;
		return CELL_W'(int'(hi_delta) - q);
	endfunction

	// raise every cell on the positive side of the line, saturating
	task automatic raise_behind_line(input int x1, input int z1, input int x2, input int z2,
			input logic [CELL_W-1:0] h);
		int dx;
		int dz;
		int side;
		logic [CELL_W:0] sum;
		dx = x2 - x1;
		dz = z2 - z1;
		for (int z = 0; z < GRID; z++) begin
			for (int x = 0; x < GRID; x++) begin
				side = (x - x1) * dz - dx * (z - z1);
				if (side > 0) begin
					sum = {1'b0, height_model[z*GRID + x]} + {1'b0, h};
					height_model[z*GRID + x] = sum[CELL_W] ? CELL_TOP : sum[CELL_W-1:0];
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ffh_result_t due;
		ffh_result_t r;
		int total;
		if (!arst_n) begin
			for (int i = 0; i < GRID*GRID; i++)
				height_model[i] = '0;
			pass_count = '0;
			hi_delta = MAX_DELTA_RST;
			lo_delta = MIN_DELTA_RST;
			pass_span = TOTAL_PASSES_RST;
			results_due.delete();
			pending = 0;
			errors = 0;
		end else begin
			// retire the result first: it always belongs to an older item
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("unexpected result item: value %0d, passes_done %0d",
						value, passes_done);
					errors = errors + 1;
				end else begin
					due = results_due.pop_front();
					if (value !== due.value) begin
						$error("value: expected %0d, got %0d", due.value, value);
						errors = errors + 1;
					end
					if (passes_done !== due.passes) begin
						$error("passes_done: expected %0d, got %0d", due.passes, passes_done);
						errors = errors + 1;
					end
				end
			end

			if (in_valid && !in_stall) begin
				r.value = '0;
				if (op == OP_READ) begin
					if (int'(cell_x) < GRID && int'(cell_z) < GRID)
						r.value = height_model[int'(cell_z)*GRID + int'(cell_x)];
				end else if (!(line_x1 == line_x2 && line_z1 == line_z2)) begin
					r.value = fault_height();
					raise_behind_line(int'(line_x1), int'(line_z1), int'(line_x2),
						int'(line_z2), r.value);
					total = (pass_span == '0) ? 1 : int'(pass_span);
					if (int'(pass_count) < total)
						pass_count = pass_count + 1'b1;
					else
						pass_count = PASS_W'(total);
				end
				r.passes = pass_count;
				results_due.push_back(r);
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_DELTA:    hi_delta = cfg_data[DELTA_W-1:0];
					REG_MIN_DELTA:    lo_delta = cfg_data[DELTA_W-1:0];
					REG_TOTAL_PASSES: pass_span = cfg_data[PASS_W-1:0];
					default: ;
				endcase
			end

			pending = results_due.size();
		end
	end

endmodule

`default_nettype wire

// File: bench/tb_fault_formation_heightmap.sv
// ----------------------------------------------------------------------------
// tb_fault_formation_heightmap - testbench for the fault formation height map
// Directed faults and reads across the register extremes, then random phases
// under bursty input and stalled output; a checker beside the block predicts
// and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_fault_formation_heightmap;
	import ffh_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [COORD_W-1:0]   EDGE = '1;
	localparam int WATCHDOG_LIMIT = 80000;
	localparam int PHASE_ITEMS = 20;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  op = OP_FAULT;
	logic [COORD_W-1:0]    line_x1 = '0;
	logic [COORD_W-1:0]    line_z1 = '0;
	logic [COORD_W-1:0]    line_x2 = '0;
	logic [COORD_W-1:0]    line_z2 = '0;
	logic [COORD_W-1:0]    cell_x = '0;
	logic [COORD_W-1:0]    cell_z = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [CELL_W-1:0]     value;
	logic [PASS_W-1:0]     passes_done;
	int                    pending;
	int                    errors;

	int burst_left = 0;
	int seg_left = 0;
	int seg_mode = 0;
	int run_left = 0;
	int idle_cycles = 0;

	always #2 clk = ~clk;

	fault_formation_heightmap dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.line_x1    (line_x1),
		.line_z1    (line_z1),
		.line_x2    (line_x2),
		.line_z2    (line_z2),
		.cell_x     (cell_x),
		.cell_z     (cell_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.passes_done(passes_done)
	);

	ffh_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.line_x1    (line_x1),
		.line_z1    (line_z1),
		.line_x2    (line_x2),
		.line_z2    (line_z2),
		.cell_x     (cell_x),
		.cell_z     (cell_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.passes_done(passes_done),
		.pending    (pending),
		.errors     (errors)
	);

	// receiver: segments of no stall, scattered stalls, or long stall runs
	always @(negedge clk) begin
		if (seg_left == 0) begin
			seg_mode = $urandom_range(0, 2);
			seg_left = $urandom_range(20, 200);
		end else begin
			seg_left = seg_left - 1;
		end
		case (seg_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (run_left > 0) begin
					run_left = run_left - 1;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 7) == 0)
						run_left = $urandom_range(1, 25);
				end
			end
		endcase
	end

	// end the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// drop valid and hold until every predicted result has been taken
	task automatic settle();
		in_valid = 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic issue(input logic o, input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] z1,
			input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] z2,
			input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cz);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) == 0) begin
				gap = 0;
				burst_left = $urandom_range(15, 40);
			end else begin
				gap = $urandom_range(0, 6);
				burst_left = $urandom_range(1, 8);
			end
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid = 1'b1;
		op = o;
		line_x1 = x1;
		line_z1 = z1;
		line_x2 = x2;
		line_z2 = z2;
		cell_x = cx;
		cell_z = cz;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left = burst_left - 1;
	endtask

	task automatic fault(input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] z1,
			input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] z2);
		issue(OP_FAULT, x1, z1, x2, z2, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	task automatic read_cell(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cz);
		issue(OP_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), cx, cz);
	endtask

	// mostly reads, a third faults, a few of them with coinciding points
	task automatic random_phase(input int n);
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] z1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 14) == 0)
				settle();
			if ($urandom_range(0, 99) < 35) begin
				x1 = COORD_W'($urandom);
				z1 = COORD_W'($urandom);
				if ($urandom_range(0, 9) == 0)
					fault(x1, z1, x1, z1);
				else
					fault(x1, z1, COORD_W'($urandom), COORD_W'($urandom));
			end else begin
				read_cell(COORD_W'($urandom), COORD_W'($urandom));
			end
		end
		settle();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: corners, coinciding points, both diagonals
		read_cell(7'd0, 7'd0);
		fault(7'd0, 7'd0, 7'd0, 7'd0);
		fault(7'd0, 7'd0, EDGE, EDGE);
		read_cell(EDGE, 7'd0);
		read_cell(7'd0, EDGE);
		fault(EDGE, 7'd0, 7'd0, EDGE);
		fault(EDGE, EDGE, EDGE, EDGE);
		fault(7'd0, EDGE, EDGE, 7'd0);
		read_cell(EDGE, EDGE);
		read_cell(7'd64, 7'd63);
		settle();

		// rising height, then the count reaches the total and holds
		write_reg(REG_MAX_DELTA, 16'hFF0A);
		write_reg(REG_MIN_DELTA, 16'h00C8);
		write_reg(REG_TOTAL_PASSES, 16'd5);
		fault(7'd10, 7'd5, 7'd90, 7'd120);
		fault(7'd120, 7'd3, 7'd7, 7'd99);
		fault(7'd1, 7'd126, 7'd126, 7'd1);
		read_cell(7'd100, 7'd20);
		read_cell(7'd5, 7'd110);
		settle();

		// total lowered below the count already done
		write_reg(REG_TOTAL_PASSES, 16'd2);
		fault(7'd30, 7'd40, 7'd31, 7'd40);
		settle();

		// zero total counts as one
		write_reg(REG_TOTAL_PASSES, 16'd0);
		fault(7'd64, 7'd0, 7'd64, EDGE);
		read_cell(7'd70, 7'd70);
		settle();

		write_reg(REG_MAX_DELTA, 16'd0);
		write_reg(REG_MIN_DELTA, 16'd0);
		write_reg(REG_TOTAL_PASSES, 16'hFFFF);
		write_reg(REG_SPARE, 16'hFFFF);
		fault(7'd2, 7'd90, 7'd80, 7'd3);
		read_cell(7'd90, 7'd90);
		settle();

		write_reg(REG_MAX_DELTA, 16'd255);
		write_reg(REG_MIN_DELTA, 16'd0);
		write_reg(REG_TOTAL_PASSES, CFG_DATA_W'($urandom_range(1, 16)));
		random_phase(PHASE_ITEMS);

		write_reg(REG_MAX_DELTA, CFG_DATA_W'($urandom));
		write_reg(REG_MIN_DELTA, CFG_DATA_W'($urandom));
		write_reg(REG_TOTAL_PASSES, CFG_DATA_W'($urandom_range(1, 65535)));
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		random_phase(PHASE_ITEMS);

		write_reg(REG_MAX_DELTA, 16'd0);
		write_reg(REG_MIN_DELTA, 16'd255);
		write_reg(REG_TOTAL_PASSES, 16'hFFFF);
		random_phase(PHASE_ITEMS);

		write_reg(REG_MAX_DELTA, 16'd255);
		write_reg(REG_MIN_DELTA, 16'd255);
		write_reg(REG_TOTAL_PASSES, CFG_DATA_W'($urandom_range(20, 60)));
		random_phase(PHASE_ITEMS);

		write_reg(REG_MAX_DELTA, CFG_DATA_W'($urandom));
		write_reg(REG_MIN_DELTA, CFG_DATA_W'($urandom));
		write_reg(REG_TOTAL_PASSES, CFG_DATA_W'($urandom_range(1, 200)));
		random_phase(PHASE_ITEMS);

		settle();
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
